### sv/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants of the polygon transform and measure unit.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W        = 40;
  localparam int IDX_W        = 3;

  localparam logic [IDX_W-1:0] REG_OFFSET_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_COS_ANGLE = 3'd2;
  localparam logic [IDX_W-1:0] REG_SIN_ANGLE = 3'd3;

  localparam logic KIND_VERTEX  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic               fin;
  } q_entry_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] edge_x;
    logic signed [31:0] edge_y;
    logic               edge_valid;
    logic [47:0]        area;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic [31:0]        box_width;
    logic [31:0]        box_height;
    logic               last;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### sv/ptm_fifo.sv
// ----------------------------------------------------------------------------
// ptm_fifo
// Two-entry queue between the transform front and the measurement back.
// ----------------------------------------------------------------------------
module ptm_fifo import ptm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_data,
  output logic     empty
);

  q_entry_t   mem [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rp_r];

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/ptm_front.sv
// ----------------------------------------------------------------------------
// ptm_front
// Holds the configuration, accepts local vertices and rotates and offsets
// them into world coordinates, then hands them to the queue.
// ----------------------------------------------------------------------------
module ptm_front import ptm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_local_x,
  input  logic signed [31:0]  in_local_y,
  input  logic                in_final_vertex,
  output logic                q_push,
  output q_entry_t            q_data,
  input  logic                q_full
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MX   = 5'b00010,
    F_MY   = 5'b00100,
    F_WY   = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t            st_r, st_nxt;
  logic signed [31:0] off_x_r, off_y_r;
  logic signed [15:0] cos_r, sin_r;
  logic signed [31:0] lx_r, ly_r, wx_r, wy_r;
  logic               fin_r;
  logic signed [47:0] pa_r, pb_r;
  logic signed [49:0] psum;
  logic signed [35:0] pshift;
  logic signed [36:0] wsum;
  logic signed [31:0] wsat;

  assign in_full = (st_r != F_IDLE);
  assign q_push  = (st_r == F_PUSH);
  assign q_data  = '{lx: lx_r, ly: ly_r, wx: wx_r, wy: wy_r, fin: fin_r};

  always_comb begin
    if (st_r == F_MY) begin
      psum = 50'(pa_r) - 50'(pb_r) + 50'sd8192;
    end else begin
      psum = 50'(pa_r) + 50'(pb_r) + 50'sd8192;
    end
    pshift = psum[49:14];
    wsum   = 37'(pshift) + 37'((st_r == F_MY) ? off_x_r : off_y_r);
    wsat   = sat32(41'(wsum));
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE:  if (in_push) st_nxt = F_MX;
      F_MX:    st_nxt = F_MY;
      F_MY:    st_nxt = F_WY;
      F_WY:    st_nxt = F_PUSH;
      F_PUSH:  if (!q_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: begin
        lx_r  <= in_local_x;
        ly_r  <= in_local_y;
        fin_r <= in_final_vertex;
      end
      F_MX: begin
        pa_r <= lx_r * cos_r;
        pb_r <= ly_r * sin_r;
      end
      F_MY: begin
        wx_r <= wsat;
        pa_r <= lx_r * sin_r;
        pb_r <= ly_r * cos_r;
      end
      F_WY: begin
        wy_r <= wsat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      off_x_r <= '0;
      off_y_r <= '0;
      cos_r   <= 16'sd16384;
      sin_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_X:  off_x_r <= cfg_wdata;
          REG_OFFSET_Y:  off_y_r <= cfg_wdata;
          REG_COS_ANGLE: cos_r   <= cfg_wdata[15:0];
          REG_SIN_ANGLE: sin_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### sv/ptm_back.sv
// ----------------------------------------------------------------------------
// ptm_back
// Accumulates area, sums and extremes per polygon, forms edges, divides the
// sums for the centroid and drives the result register.
// ----------------------------------------------------------------------------
module ptm_back import ptm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  q_entry_t q_data,
  input  logic     q_empty,
  output logic     q_pop,
  output result_t  res,
  output logic     res_empty,
  input  logic     res_pop
);

  typedef enum logic [9:0] {
    B_IDLE  = 10'b0000000001,
    B_MUL   = 10'b0000000010,
    B_TERM  = 10'b0000000100,
    B_ACC   = 10'b0000001000,
    B_OUTV  = 10'b0000010000,
    B_CMUL  = 10'b0000100000,
    B_CTERM = 10'b0001000000,
    B_CACC  = 10'b0010000000,
    B_DIV   = 10'b0100000000,
    B_OUTS  = 10'b1000000000
  } bstate_t;

  bstate_t             st_r, st_nxt;
  q_entry_t            cur_r;
  logic signed [63:0]  m1_r, m2_r, term_r, area_r;
  logic signed [31:0]  fl_x_r, fl_y_r, pl_x_r, pl_y_r;
  logic signed [31:0]  fw_x_r, fw_y_r, pw_x_r, pw_y_r;
  logic signed [31:0]  min_x_r, min_y_r, max_x_r, max_y_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r;
  logic [CNT_W-1:0]    cnt_r, cnt_inc;
  logic [SUM_W-1:0]    dx_r, dy_r, qx_r, qy_r;
  logic [CNT_W-1:0]    rx_r, ry_r;
  logic [CNT_W:0]      rx_t, ry_t;
  logic                negx_r, negy_r;
  logic [5:0]          step_r;
  logic                ov_r;
  logic                slot_free;
  logic                closing;
  logic signed [31:0]  ma1, mb1, ma2, mb2;
  logic signed [64:0]  dsub, dadd;
  logic signed [63:0]  sub_sat, add_sat;
  logic signed [41:0]  sx_t, sy_t;
  logic signed [SUM_W-1:0] sx_sat, sy_sat;
  logic [63:0]         amag;
  logic signed [40:0]  cx_t, cy_t;

  assign slot_free = !ov_r || res_pop;
  assign res_empty = !ov_r;
  assign q_pop     = (st_r == B_IDLE) && !q_empty;
  assign cnt_inc   = cnt_r + 1'b1;
  assign closing   = cur_r.fin || (cnt_inc == CNT_W'(MAX_VERTICES));

  always_comb begin
    if (st_r == B_CMUL) begin
      ma1 = fl_x_r;  mb1 = cur_r.ly;
      ma2 = cur_r.lx; mb2 = fl_y_r;
    end else begin
      ma1 = cur_r.lx; mb1 = pl_y_r;
      ma2 = pl_x_r;  mb2 = cur_r.ly;
    end
    dsub = 65'(m1_r) - 65'(m2_r);
    if (dsub[64] != dsub[63]) begin
      sub_sat = dsub[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sub_sat = dsub[63:0];
    end
    dadd = 65'(area_r) + 65'(term_r);
    if (dadd[64] != dadd[63]) begin
      add_sat = dadd[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      add_sat = dadd[63:0];
    end
    sx_t = 42'(sum_x_r) + 42'(cur_r.wx);
    sy_t = 42'(sum_y_r) + 42'(cur_r.wy);
    if (sx_t > 42'sd549755813887) begin
      sx_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (sx_t < -42'sd549755813888) begin
      sx_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sx_sat = sx_t[SUM_W-1:0];
    end
    if (sy_t > 42'sd549755813887) begin
      sy_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (sy_t < -42'sd549755813888) begin
      sy_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sy_sat = sy_t[SUM_W-1:0];
    end
    rx_t = {rx_r, dx_r[SUM_W-1]};
    ry_t = {ry_r, dy_r[SUM_W-1]};
    amag = area_r[63] ? (64'd0 - area_r) : area_r;
    cx_t = negx_r ? -41'(qx_r) : 41'(qx_r);
    cy_t = negy_r ? -41'(qy_r) : 41'(qy_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:  if (!q_empty) st_nxt = B_MUL;
      B_MUL:   st_nxt = B_TERM;
      B_TERM:  st_nxt = B_ACC;
      B_ACC:   st_nxt = B_OUTV;
      B_OUTV:  if (slot_free) st_nxt = closing ? B_CMUL : B_IDLE;
      B_CMUL:  st_nxt = B_CTERM;
      B_CTERM: st_nxt = B_CACC;
      B_CACC:  st_nxt = B_DIV;
      B_DIV:   if (step_r == 6'(SUM_W - 1)) st_nxt = B_OUTS;
      B_OUTS:  if (slot_free) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE:  cur_r <= q_data;
      B_MUL, B_CMUL: begin
        m1_r <= ma1 * mb1;
        m2_r <= ma2 * mb2;
      end
      B_TERM, B_CTERM: term_r <= sub_sat;
      B_CACC: begin
        negx_r <= sum_x_r[SUM_W-1];
        negy_r <= sum_y_r[SUM_W-1];
        dx_r   <= sum_x_r[SUM_W-1] ? (SUM_W'(0) - sum_x_r) : sum_x_r;
        dy_r   <= sum_y_r[SUM_W-1] ? (SUM_W'(0) - sum_y_r) : sum_y_r;
        rx_r   <= '0;
        ry_r   <= '0;
        qx_r   <= '0;
        qy_r   <= '0;
      end
      B_DIV: begin
        dx_r <= dx_r << 1;
        dy_r <= dy_r << 1;
        if (rx_t >= {1'b0, cnt_r}) begin
          rx_r <= CNT_W'(rx_t - {1'b0, cnt_r});
          qx_r <= {qx_r[SUM_W-2:0], 1'b1};
        end else begin
          rx_r <= rx_t[CNT_W-1:0];
          qx_r <= {qx_r[SUM_W-2:0], 1'b0};
        end
        if (ry_t >= {1'b0, cnt_r}) begin
          ry_r <= CNT_W'(ry_t - {1'b0, cnt_r});
          qy_r <= {qy_r[SUM_W-2:0], 1'b1};
        end else begin
          ry_r <= ry_t[CNT_W-1:0];
          qy_r <= {qy_r[SUM_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (st_r == B_OUTV && slot_free) begin
      res.kind       <= KIND_VERTEX;
      res.x_value    <= cur_r.wx;
      res.y_value    <= cur_r.wy;
      res.edge_x     <= (cnt_r != '0) ? sat32(41'(cur_r.wx) - 41'(pw_x_r)) : '0;
      res.edge_y     <= (cnt_r != '0) ? sat32(41'(cur_r.wy) - 41'(pw_y_r)) : '0;
      res.edge_valid <= (cnt_r != '0);
      res.area       <= '0;
      res.box_min_x  <= '0;
      res.box_min_y  <= '0;
      res.box_width  <= '0;
      res.box_height <= '0;
      res.last       <= 1'b0;
      if (cnt_r == '0) begin
        fl_x_r <= cur_r.lx;
        fl_y_r <= cur_r.ly;
        fw_x_r <= cur_r.wx;
        fw_y_r <= cur_r.wy;
      end
      pl_x_r <= cur_r.lx;
      pl_y_r <= cur_r.ly;
      pw_x_r <= cur_r.wx;
      pw_y_r <= cur_r.wy;
    end
    if (st_r == B_OUTS && slot_free) begin
      res.kind       <= KIND_SUMMARY;
      res.x_value    <= sat32(cx_t);
      res.y_value    <= sat32(cy_t);
      res.edge_x     <= sat32(41'(fw_x_r) - 41'(pw_x_r));
      res.edge_y     <= sat32(41'(fw_y_r) - 41'(pw_y_r));
      res.edge_valid <= 1'b1;
      res.area       <= {1'b0, amag[63:17]};
      res.box_min_x  <= min_x_r;
      res.box_min_y  <= min_y_r;
      res.box_width  <= 32'(33'(max_x_r) - 33'(min_x_r));
      res.box_height <= 32'(33'(max_y_r) - 33'(min_y_r));
      res.last       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      ov_r    <= 1'b0;
      step_r  <= '0;
      area_r  <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
      min_x_r <= 32'sh7FFFFFFF;
      min_y_r <= 32'sh7FFFFFFF;
      max_x_r <= 32'sh80000000;
      max_y_r <= 32'sh80000000;
    end else begin
      st_r <= st_nxt;
      if ((st_r == B_OUTV || st_r == B_OUTS) && slot_free) begin
        ov_r <= 1'b1;
      end else if (res_pop) begin
        ov_r <= 1'b0;
      end
      if (st_r == B_ACC && cnt_r != '0) begin
        area_r <= add_sat;
      end
      if (st_r == B_CACC) begin
        area_r <= add_sat;
        step_r <= '0;
      end
      if (st_r == B_DIV) begin
        step_r <= step_r + 1'b1;
      end
      if (st_r == B_OUTV && slot_free) begin
        cnt_r   <= cnt_inc;
        sum_x_r <= sx_sat;
        sum_y_r <= sy_sat;
        if (cur_r.wx < min_x_r) min_x_r <= cur_r.wx;
        if (cur_r.wy < min_y_r) min_y_r <= cur_r.wy;
        if (cur_r.wx > max_x_r) max_x_r <= cur_r.wx;
        if (cur_r.wy > max_y_r) max_y_r <= cur_r.wy;
      end
      if (st_r == B_OUTS && slot_free) begin
        area_r  <= '0;
        sum_x_r <= '0;
        sum_y_r <= '0;
        cnt_r   <= '0;
        min_x_r <= 32'sh7FFFFFFF;
        min_y_r <= 32'sh7FFFFFFF;
        max_x_r <= 32'sh80000000;
        max_y_r <= 32'sh80000000;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES)) else $error("vertex count past limit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  a_clear_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_OUTS && slot_free) |=> (cnt_r == '0 && ov_r && res.last))
    else $error("summary not issued or polygon not cleared");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !res_pop) |=> $stable(res)) else $error("result overwritten");

endmodule

### sv/polygon_transform_and_measure_unit.sv
// ----------------------------------------------------------------------------
// polygon_transform_and_measure_unit
// Rigid transform of polygon vertices with edge, area, centroid and box.
// ----------------------------------------------------------------------------
// Push local vertices while full is low; mark the last one with
// in_final_vertex. Each vertex gives one vertex word on the result side;
// the last one (or the vertex that reaches the vertex limit) gives a summary
// word after it. Read results with out_pop while out_empty is low.
// The front handles one vertex at a time: two rounds of the rotation
// multipliers, then the hand-off into a two-entry queue. The back
// forms each vertex word by cross product, saturating area add and
// output load, and closes each polygon with the closing term and the
// 40-step bit-serial centroid division.
// Configuration writes land at once; write only while the block is idle.
// Reset restores unit rotation and zero offset and clears polygon state.
// When the receiver stalls, the result register holds, the back waits on it,
// the queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module polygon_transform_and_measure_unit import ptm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_local_x,
  input  logic signed [31:0] in_local_y,
  input  logic               in_final_vertex,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_kind,
  output logic signed [31:0] out_x_value,
  output logic signed [31:0] out_y_value,
  output logic signed [31:0] out_edge_x,
  output logic signed [31:0] out_edge_y,
  output logic               out_edge_valid,
  output logic [47:0]        out_area,
  output logic signed [31:0] out_box_min_x,
  output logic signed [31:0] out_box_min_y,
  output logic [31:0]        out_box_width,
  output logic [31:0]        out_box_height,
  output logic               out_last
);

  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_wdata, q_rdata;
  result_t  res;

  ptm_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_push, .in_full, .in_local_x, .in_local_y, .in_final_vertex,
    .q_push, .q_data(q_wdata), .q_full
  );

  ptm_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  ptm_back u_back (
    .clk, .rst_n, .q_data(q_rdata), .q_empty, .q_pop,
    .res, .res_empty(out_empty), .res_pop(out_pop)
  );

  assign out_kind       = res.kind;
  assign out_x_value    = res.x_value;
  assign out_y_value    = res.y_value;
  assign out_edge_x     = res.edge_x;
  assign out_edge_y     = res.edge_y;
  assign out_edge_valid = res.edge_valid;
  assign out_area       = res.area;
  assign out_box_min_x  = res.box_min_x;
  assign out_box_min_y  = res.box_min_y;
  assign out_box_width  = res.box_width;
  assign out_box_height = res.box_height;
  assign out_last       = res.last;

endmodule
